/* design/snbm_pkg.sv */
// Shared types and constants for the span nearest/bracket mapper.
// Request/response payload structs, register map, mode and function codes.
// No dependencies.
package snbm_pkg;

  localparam int MAX_SPANS = 64;

  localparam int IDX_W  = 7;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 17;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // interp_mode codes
  localparam logic [1:0] MODE_MATCH   = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_LINEAR  = 2'd2;
  localparam logic [1:0] MODE_UNSUP   = 2'd3;

  // request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAP  = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_DONORS  = 2'd1;
  localparam logic [1:0] REG_TARGETS = 2'd2;
  localparam logic [1:0] REG_3D      = 2'd3;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] span_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] donor_span;
    logic [WGT_W-1:0] weight;
    logic             out_of_bounds;
    logic             mode_error;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       interp_mode;
    logic [IDX_W-1:0] donor_count;
    logic [IDX_W-1:0] target_count;
    logic             three_dim;
  } cfg_t;

endpackage

/* design/span_nearest_or_bracket_mapper.sv */
// Top level of the span nearest/bracket mapper: registers, donor table,
// sequencer and weight divider. Depends on snbm_pkg, snbm_cfg, snbm_mem,
// snbm_div and snbm_ctrl.
//
//   channel  handshake               payload
//   in       in_valid_i / in_ready_o  in_req_i  (func, entry_index, span_value)
//   out      out_valid_o / out_ready_i out_rsp_o (donor_span, weight, flags)
//   cfg      psel/penable/pwrite/pready paddr, pwdata, prdata (APB write/read)
//
// A load request writes its table entry from the idle state. Hub, shroud,
// matching and unsupported-mode queries go straight to the output. Nearest runs
// the compare pipeline, reading one table entry per cycle; linear adds the
// bracket fetch and the 17-step divider.
// The table is not cleared after reset; requests are taken right away.
// A finished response waits in the output register while the next request runs.
module span_nearest_or_bracket_mapper import snbm_pkg::*; #(
  parameter int MaxSpans = MAX_SPANS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int Depth = MaxSpans + 1;
  localparam int AddrW = $clog2(MaxSpans + 1);

  cfg_t             cfg;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;
  logic             div_start, div_done;
  logic [VAL_W-1:0] div_num, div_den;
  logic [WGT_W-1:0] div_quot;

  snbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  snbm_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  snbm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  snbm_ctrl #(
    .MaxSpans (MaxSpans),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot)
  );

endmodule

/* design/snbm_cfg.sv */
// APB register file for the span mapper: mode, donor/target counts, 3D enable.
// Values are held raw; clamping happens where they are used.
// Depends on snbm_pkg.
module snbm_cfg import snbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (paddr[3:2])
        REG_MODE:    cfg_d.interp_mode  = pwdata[1:0];
        REG_DONORS:  cfg_d.donor_count  = pwdata[IDX_W-1:0];
        REG_TARGETS: cfg_d.target_count = pwdata[IDX_W-1:0];
        REG_3D:      cfg_d.three_dim    = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:    prdata = APB_DW'(cfg_q.interp_mode);
      REG_DONORS:  prdata = APB_DW'(cfg_q.donor_count);
      REG_TARGETS: prdata = APB_DW'(cfg_q.target_count);
      REG_3D:      prdata = APB_DW'(cfg_q.three_dim);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interp_mode  <= MODE_MATCH;
      cfg_q.donor_count  <= IDX_W'(2);
      cfg_q.target_count <= IDX_W'(2);
      cfg_q.three_dim    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/snbm_mem.sv */
// Donor span table: one write port, one read port with registered read data.
// Contents are undefined until written.
// Depends on snbm_pkg.
module snbm_mem import snbm_pkg::*; #(
  parameter int Depth = MAX_SPANS + 1,
  parameter int AddrW = $clog2(MAX_SPANS + 1)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [VAL_W-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem_q [Depth];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/snbm_div.sv */
// Radix-2 restoring divider for the Q1.16 weight: quot = (num << 16) / den.
// Expects num <= den, so the quotient fits 17 bits; one bit per cycle.
// Depends on snbm_pkg.
module snbm_div import snbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] num_i,
  input  logic [VAL_W-1:0] den_i,
  output logic             done_o,
  output logic [WGT_W-1:0] quot_o
);

  localparam int CntW = $clog2(WGT_W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            first_q, first_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] den_q, den_d;
  logic [WGT_W-1:0] quo_q, quo_d;
  logic [VAL_W:0]   rs;
  logic [VAL_W:0]   diff;
  logic             ge;

  // first step compares without a shift (bit 16 of the quotient)
  assign rs   = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign diff = rs - {1'b0, den_q};
  assign ge   = rs >= {1'b0, den_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CntW'(WGT_W - 1);
      rem_d   = num_i;
      den_d   = den_i;
      quo_d   = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = ge ? diff[VAL_W-1:0] : rs[VAL_W-1:0];
      quo_d   = {quo_q[WGT_W-2:0], ge};
      cnt_d   = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* design/snbm_ctrl.sv */
// Sequencer for the span mapper: decodes special cases, runs the pipelined
// distance compare over the donor table, fetches the bracket, drives the divider.
// Depends on snbm_pkg; talks to snbm_mem and snbm_div.
module snbm_ctrl import snbm_pkg::*; #(
  parameter int MaxSpans = MAX_SPANS,
  parameter int AddrW    = $clog2(MAX_SPANS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_rsp_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [VAL_W-1:0] mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [VAL_W-1:0] mem_rdata_i,
  output logic             div_start_o,
  output logic [VAL_W-1:0] div_num_o,
  output logic [VAL_W-1:0] div_den_o,
  input  logic             div_done_i,
  input  logic [WGT_W-1:0] div_quot_i
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_FETCH0  = 4'd2;
  localparam logic [3:0] S_FETCH1  = 4'd3;
  localparam logic [3:0] S_FETCH2  = 4'd4;
  localparam logic [3:0] S_CHECK   = 4'd5;
  localparam logic [3:0] S_DIVGO   = 4'd6;
  localparam logic [3:0] S_DIVWAIT = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  function automatic logic [AddrW-1:0] clamp_cnt(logic [IDX_W-1:0] c);
    if (int'(c) < 2) begin
      return AddrW'(2);
    end else if (int'(c) > MaxSpans) begin
      return AddrW'(MaxSpans);
    end
    return AddrW'(c);
  endfunction

  logic [3:0]       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_rsp_q, out_rsp_d;
  rsp_t             res_q, res_d;
  logic [VAL_W-1:0] v_q, v_d;
  logic [AddrW-1:0] i_q, i_d;
  // compare pipeline: read -> difference -> distance -> best update
  logic             rd_v_q, rd_v_d;
  logic [AddrW-1:0] rd_idx_q;
  logic             df_v_q;
  logic [AddrW-1:0] df_idx_q;
  logic [VAL_W:0]   diff_q, diff_d;
  logic             ds_v_q;
  logic [AddrW-1:0] ds_idx_q;
  logic [VAL_W-1:0] dist_q, dist_d;
  logic             gt_q, gt_d;
  logic             found_q, found_d;
  logic [VAL_W-1:0] best_q, best_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  logic [VAL_W-1:0] dk_q, dk_d;
  logic [VAL_W:0]   num_q, num_d;
  logic [VAL_W:0]   den_q, den_d;
  logic [VAL_W-1:0] an_q, an_d;
  logic [VAL_W-1:0] ad_q, ad_d;

  logic [AddrW-1:0] nd, nt, scan_end;
  int               ti, nti;
  logic             issue, scan_done, cand, linear;
  logic [VAL_W:0]   neg_num, neg_den;

  assign nd       = clamp_cnt(cfg_i.donor_count);
  assign nt       = clamp_cnt(cfg_i.target_count);
  assign ti       = int'(in_req_i.entry_index);
  assign nti      = int'(nt);
  assign linear   = cfg_i.interp_mode == MODE_LINEAR;
  assign scan_end = nd - AddrW'(1);
  assign issue    = (state_q == S_SCAN) && (i_q < scan_end);
  assign scan_done = !issue && !rd_v_q && !df_v_q && !ds_v_q;
  assign cand     = linear ? gt_q : 1'b1;
  assign neg_num  = -num_q;
  assign neg_den  = -den_q;

  assign in_ready_o  = state_q == S_IDLE;
  assign mem_wdata_o = in_req_i.span_value;
  assign mem_waddr_o = AddrW'(in_req_i.entry_index);
  assign div_num_o   = an_q;
  assign div_den_o   = ad_q;

  // pipeline datapath of the shared compare
  assign rd_v_d = issue;
  assign diff_d = {v_q[VAL_W-1], v_q} - {mem_rdata_i[VAL_W-1], mem_rdata_i};
  assign dist_d = diff_q[VAL_W] ? VAL_W'(-diff_q) : diff_q[VAL_W-1:0];
  assign gt_d   = !diff_q[VAL_W] && (diff_q != '0);

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    v_d         = v_q;
    i_d         = i_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    dk_d        = dk_q;
    num_d       = num_q;
    den_d       = den_q;
    an_d        = an_q;
    ad_d        = ad_q;
    mem_we_o    = 1'b0;
    mem_raddr_o = i_q;
    div_start_o = 1'b0;

    // best-candidate update at the end of the compare pipeline
    if (ds_v_q && cand && (!found_q || dist_q < best_q)) begin
      found_d    = 1'b1;
      best_d     = dist_q;
      best_idx_d = ds_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.func == FUNC_LOAD) begin
            mem_we_o = ti <= MaxSpans;
          end else begin
            v_d   = in_req_i.span_value;
            res_d = '0;
            if (ti == 0 || ti > nti) begin
              state_d = S_FIN;
            end else if (ti >= nti - 1) begin
              // shroud and average span in 3D; hub donor otherwise
              if (cfg_i.three_dim) begin
                res_d.donor_span = (ti == nti) ? IDX_W'(nd) : IDX_W'(nd - AddrW'(1));
              end
              state_d = S_FIN;
            end else begin
              unique case (cfg_i.interp_mode)
                MODE_MATCH: begin
                  res_d.donor_span = in_req_i.entry_index;
                  state_d = S_FIN;
                end
                MODE_NEAREST, MODE_LINEAR: begin
                  i_d        = linear ? AddrW'(1) : '0;
                  found_d    = 1'b0;
                  best_idx_d = '0;
                  state_d    = S_SCAN;
                end
                MODE_UNSUP: begin
                  res_d.mode_error = 1'b1;
                  state_d = S_FIN;
                end
                default: state_d = S_FIN;
              endcase
            end
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          i_d = i_q + AddrW'(1);
        end
        if (scan_done) begin
          res_d.donor_span = IDX_W'(best_idx_q);
          state_d = linear ? S_FETCH0 : S_FIN;
        end
      end
      S_FETCH0: begin
        mem_raddr_o = best_idx_q;
        state_d     = S_FETCH1;
      end
      S_FETCH1: begin
        mem_raddr_o = best_idx_q + AddrW'(1);
        dk_d        = mem_rdata_i;
        num_d       = {v_q[VAL_W-1], v_q} - {mem_rdata_i[VAL_W-1], mem_rdata_i};
        state_d     = S_FETCH2;
      end
      S_FETCH2: begin
        den_d   = {mem_rdata_i[VAL_W-1], mem_rdata_i} - {dk_q[VAL_W-1], dk_q};
        state_d = S_CHECK;
      end
      S_CHECK: begin
        an_d    = num_q[VAL_W] ? neg_num[VAL_W-1:0] : num_q[VAL_W-1:0];
        ad_d    = den_q[VAL_W] ? neg_den[VAL_W-1:0] : den_q[VAL_W-1:0];
        state_d = S_FIN;
        if (den_q == '0) begin
          res_d.out_of_bounds = 1'b1;
        end else if (num_q == '0) begin
          res_d.weight = '0;
        end else if (num_q[VAL_W] != den_q[VAL_W]) begin
          res_d.out_of_bounds = 1'b1;
        end else begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        if (an_q > ad_q) begin
          res_d.out_of_bounds = 1'b1;
          state_d = S_FIN;
        end else begin
          div_start_o = 1'b1;
          state_d     = S_DIVWAIT;
        end
      end
      S_DIVWAIT: begin
        if (div_done_i) begin
          res_d.weight = div_quot_i;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_rsp_d   = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
      df_v_q      <= 1'b0;
      ds_v_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_v_q      <= rd_v_d;
      df_v_q      <= rd_v_q;
      ds_v_q      <= df_v_q;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q  <= out_rsp_d;
    res_q      <= res_d;
    v_q        <= v_d;
    i_q        <= i_d;
    rd_idx_q   <= i_q;
    df_idx_q   <= rd_idx_q;
    diff_q     <= diff_d;
    ds_idx_q   <= df_idx_q;
    dist_q     <= dist_d;
    gt_q       <= gt_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    dk_q       <= dk_d;
    num_q      <= num_d;
    den_q      <= den_d;
    an_q       <= an_d;
    ad_q       <= ad_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
